[src/cvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared widths, types and helpers of the streaming 2D convolution block.
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int KMAX       = 3;
  localparam int PIXEL_BITS = 16;
  localparam int LS_AW      = $clog2(MAX_WIDTH);

  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = 32;
  localparam int RSUM_W = 34;
  localparam int SUM_W  = 36;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int IW_W   = 11;
  localparam int KW_W   = 2;
  localparam int CROW_W = 48;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  // register map, 8 bytes per register
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH = 3'd3,
    REG_COEF_ROW0    = 3'd4,
    REG_COEF_ROW1    = 3'd5,
    REG_COEF_ROW2    = 3'd6
  } cvs_reg_e;

  localparam logic [IW_W-1:0]   IMAGE_WIDTH_RST  = 11'd4;
  localparam logic [ROW_W-1:0]  IMAGE_HEIGHT_RST = 12'd4;
  localparam logic [KW_W-1:0]   KERNEL_DIM_RST   = 2'd2;
  localparam logic [CROW_W-1:0] COEF_ROW0_RST    = 48'd4096;
  localparam logic [CROW_W-1:0] COEF_ROW1_RST    = 48'd268435456;
  localparam logic [CROW_W-1:0] COEF_ROW2_RST    = 48'd0;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } cvs_meta_t;

  // one coefficient of a packed kernel row, column 0 in the low bits
  function automatic logic signed [COEF_W-1:0] coef_pick(
    input logic [CROW_W-1:0] row,
    input logic [KW_W-1:0]   col
  );
    logic signed [COEF_W-1:0] c;
    case (col)
      2'd0:    c = row[15:0];
      2'd1:    c = row[31:16];
      2'd2:    c = row[47:32];
      default: c = '0;
    endcase
    return c;
  endfunction

  // kernel size of zero behaves as one
  function automatic logic [KW_W-1:0] kdim_eff(input logic [KW_W-1:0] k);
    return (k == '0) ? KW_W'(1) : k;
  endfunction

endpackage

[src/cvs_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pix_if
// Pixel stream channel: valid/ready handshake with one signed Q8.8 pixel.
// ----------------------------------------------------------------------------
interface cvs_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvs_pkg::PIX_W-1:0]    pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[src/cvs_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_res_if
// Result stream channel: valid/ready handshake with one window sum and its
// position in the output frame.
// ----------------------------------------------------------------------------
interface cvs_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvs_pkg::SUM_W-1:0]    sum;
  logic        [cvs_pkg::ROW_W-1:0]    out_row;
  logic        [cvs_pkg::COL_W-1:0]    out_col;
  logic                                frame_last;

  modport source (output valid, output sum, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input sum, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

[src/conv2d_valid_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_valid_stream
// Streaming 'valid' 2D convolution with a kernel of up to 3 by 3.
// ----------------------------------------------------------------------------
// Pixels enter on pix_i in raster order, one per transaction. For every
// window that lies wholly inside the frame, res_o carries the Q16.20 sum of
// products (kernel not flipped), the row and column of the window's top-left
// corner, and frame_last on the final result of the frame.
// Image and kernel sizes and the coefficients sit in APB registers at byte
// address 8*i; write them only while no transaction is in flight.
// Throughput: one pixel per clock while res_o is not stalled. The two previous
// rows live in one line store word per column, read when a pixel is taken and
// written back from stage 1, with a one-deep bypass for a repeated column.
// A result passes through the line store read, window shift, products, row
// sums and final sum registers before it reaches res_o.
// When res_o is stalled the whole pipeline holds and pix_i.ready drops, so
// nothing is lost; an output register keeps the held result.
// Reset clears the pipeline, the counters and the window and loads the
// default register values; the line store is not cleared, as every entry
// is written before a result depends on it.
// ----------------------------------------------------------------------------
module conv2d_valid_stream (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cvs_pix_if.sink                        pix_i,
  cvs_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cvs_pkg::APB_AW-1:0]     paddr,
  input  logic [cvs_pkg::APB_DW-1:0]     pwdata,
  output logic [cvs_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int K = cvs_pkg::KMAX;

  // configuration registers
  logic [cvs_pkg::IW_W-1:0]   img_w_q;
  logic [cvs_pkg::ROW_W-1:0]  img_h_q;
  logic [cvs_pkg::KW_W-1:0]   ker_h_q;
  logic [cvs_pkg::KW_W-1:0]   ker_w_q;
  logic [cvs_pkg::CROW_W-1:0] coef_q [K];

  cvs_pkg::cvs_reg_e reg_idx;
  logic              cfg_we;

  assign reg_idx = cvs_pkg::cvs_reg_e'(paddr[5:3]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= cvs_pkg::IMAGE_WIDTH_RST;
      img_h_q   <= cvs_pkg::IMAGE_HEIGHT_RST;
      ker_h_q   <= cvs_pkg::KERNEL_DIM_RST;
      ker_w_q   <= cvs_pkg::KERNEL_DIM_RST;
      coef_q[0] <= cvs_pkg::COEF_ROW0_RST;
      coef_q[1] <= cvs_pkg::COEF_ROW1_RST;
      coef_q[2] <= cvs_pkg::COEF_ROW2_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        cvs_pkg::REG_IMAGE_WIDTH:   img_w_q   <= pwdata[cvs_pkg::IW_W-1:0];
        cvs_pkg::REG_IMAGE_HEIGHT:  img_h_q   <= pwdata[cvs_pkg::ROW_W-1:0];
        cvs_pkg::REG_KERNEL_HEIGHT: ker_h_q   <= pwdata[cvs_pkg::KW_W-1:0];
        cvs_pkg::REG_KERNEL_WIDTH:  ker_w_q   <= pwdata[cvs_pkg::KW_W-1:0];
        cvs_pkg::REG_COEF_ROW0:     coef_q[0] <= pwdata[cvs_pkg::CROW_W-1:0];
        cvs_pkg::REG_COEF_ROW1:     coef_q[1] <= pwdata[cvs_pkg::CROW_W-1:0];
        cvs_pkg::REG_COEF_ROW2:     coef_q[2] <= pwdata[cvs_pkg::CROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cvs_pkg::REG_IMAGE_WIDTH:   prdata = cvs_pkg::APB_DW'(img_w_q);
      cvs_pkg::REG_IMAGE_HEIGHT:  prdata = cvs_pkg::APB_DW'(img_h_q);
      cvs_pkg::REG_KERNEL_HEIGHT: prdata = cvs_pkg::APB_DW'(ker_h_q);
      cvs_pkg::REG_KERNEL_WIDTH:  prdata = cvs_pkg::APB_DW'(ker_w_q);
      cvs_pkg::REG_COEF_ROW0:     prdata = cvs_pkg::APB_DW'(coef_q[0]);
      cvs_pkg::REG_COEF_ROW1:     prdata = cvs_pkg::APB_DW'(coef_q[1]);
      cvs_pkg::REG_COEF_ROW2:     prdata = cvs_pkg::APB_DW'(coef_q[2]);
      default:                    prdata = '0;
    endcase
  end

  // pipeline control: every stage moves together
  logic adv;
  logic acc;
  logic out_valid_q;

  assign adv         = !out_valid_q || res_o.ready;
  assign acc         = pix_i.valid && adv;
  assign pix_i.ready = adv;

  // frame counters and derived sizes
  logic [cvs_pkg::COL_W-1:0]  col_q, col_d;
  logic [cvs_pkg::ROW_W-1:0]  row_q, row_d;
  logic [cvs_pkg::IW_W-1:0]   w_eff;
  logic [cvs_pkg::ROW_W-1:0]  h_eff;
  logic [cvs_pkg::KW_W-1:0]   kh_eff, kw_eff;
  logic [cvs_pkg::IW_W-1:0]   c_plus1;
  logic [cvs_pkg::ROW_W:0]    r_plus1;
  logic                       col_end, row_end, emit;
  cvs_pkg::cvs_meta_t         meta_d;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = cvs_pkg::IW_W'(1);
    end else if (img_w_q > cvs_pkg::IW_W'(cvs_pkg::MAX_WIDTH)) begin
      w_eff = cvs_pkg::IW_W'(cvs_pkg::MAX_WIDTH);
    end else begin
      w_eff = img_w_q;
    end
    h_eff   = (img_h_q == '0) ? cvs_pkg::ROW_W'(1) : img_h_q;
    kh_eff  = cvs_pkg::kdim_eff(ker_h_q);
    kw_eff  = cvs_pkg::kdim_eff(ker_w_q);
    c_plus1 = {1'b0, col_q} + cvs_pkg::IW_W'(1);
    r_plus1 = {1'b0, row_q} + (cvs_pkg::ROW_W+1)'(1);
    col_end = c_plus1 >= w_eff;
    row_end = r_plus1 >= {1'b0, h_eff};
    emit    = (r_plus1 >= (cvs_pkg::ROW_W+1)'(kh_eff)) &&
              (c_plus1 >= cvs_pkg::IW_W'(kw_eff));
    meta_d.out_row    = cvs_pkg::ROW_W'(r_plus1 - (cvs_pkg::ROW_W+1)'(kh_eff));
    meta_d.out_col    = cvs_pkg::COL_W'(c_plus1 - cvs_pkg::IW_W'(kw_eff));
    meta_d.frame_last = col_end && row_end;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : r_plus1[cvs_pkg::ROW_W-1:0];
    end else begin
      col_d = c_plus1[cvs_pkg::COL_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read, one word {older row, previous row} per column
  logic [2*cvs_pkg::PIX_W-1:0] ls_mem [cvs_pkg::MAX_WIDTH];
  logic [2*cvs_pkg::PIX_W-1:0] ls_rd_q;
  logic [2*cvs_pkg::PIX_W-1:0] ls_rd_eff;
  logic [2*cvs_pkg::PIX_W-1:0] ls_wdata;
  logic [2*cvs_pkg::PIX_W-1:0] fwd_word_q;
  logic                        fwd_q;
  logic                        ls_we;
  logic [cvs_pkg::LS_AW-1:0]   rd_addr;

  logic                        v1_q;
  logic                        emit1_q;
  logic signed [cvs_pkg::PIX_W-1:0] px1_q;
  logic [cvs_pkg::LS_AW-1:0]   addr1_q;
  logic [cvs_pkg::KW_W-1:0]    rb1_q, cb1_q;
  cvs_pkg::cvs_meta_t          meta1_q;

  assign rd_addr   = col_q[cvs_pkg::LS_AW-1:0];
  assign ls_rd_eff = fwd_q ? fwd_word_q : ls_rd_q;
  assign ls_wdata  = {ls_rd_eff[cvs_pkg::PIX_W-1:0], px1_q};
  assign ls_we     = adv && v1_q;

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[addr1_q] <= ls_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ls_rd_q <= ls_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      // same column written back at this edge: take the new word directly
      fwd_q <= acc && v1_q && (addr1_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fwd_word_q <= ls_wdata;
      px1_q      <= pix_i.pixel;
      addr1_q    <= rd_addr;
      emit1_q    <= emit;
      rb1_q      <= cvs_pkg::KW_W'(K) - kh_eff;
      cb1_q      <= cvs_pkg::KW_W'(K) - kw_eff;
      meta1_q    <= meta_d;
    end
  end

  // stage 2: window shift, oldest row on top
  logic signed [cvs_pkg::PIX_W-1:0] win_q [K][K];
  logic                        v2_q;
  logic [cvs_pkg::KW_W-1:0]    rb2_q, cb2_q;
  cvs_pkg::cvs_meta_t          meta2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < K; k++) begin
        for (int l = 0; l < K; l++) begin
          win_q[k][l] <= '0;
        end
      end
    end else if (adv && v1_q) begin
      for (int k = 0; k < K; k++) begin
        for (int l = 0; l < K - 1; l++) begin
          win_q[k][l] <= win_q[k][l+1];
        end
      end
      win_q[0][K-1] <= ls_rd_eff[2*cvs_pkg::PIX_W-1:cvs_pkg::PIX_W];
      win_q[1][K-1] <= ls_rd_eff[cvs_pkg::PIX_W-1:0];
      win_q[2][K-1] <= px1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rb2_q   <= rb1_q;
      cb2_q   <= cb1_q;
      meta2_q <= meta1_q;
    end
  end

  // stage 3: products, unused window positions give a zero product
  logic signed [cvs_pkg::COEF_W-1:0] coef_sel [K][K];
  logic                              tap_on   [K][K];
  logic signed [cvs_pkg::PROD_W-1:0] prod_q   [K][K];
  logic                              v3_q;
  cvs_pkg::cvs_meta_t                meta3_q;

  always_comb begin
    for (int p = 0; p < K; p++) begin
      for (int q = 0; q < K; q++) begin
        tap_on[p][q] = (cvs_pkg::KW_W'(p) >= rb2_q) && (cvs_pkg::KW_W'(q) >= cb2_q);
        if (tap_on[p][q]) begin
          coef_sel[p][q] = cvs_pkg::coef_pick(
            coef_q[cvs_pkg::KW_W'(p) - rb2_q], cvs_pkg::KW_W'(q) - cb2_q);
        end else begin
          coef_sel[p][q] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < K; p++) begin
        for (int q = 0; q < K; q++) begin
          // rows above the kernel may hold never-written line store words
          if (tap_on[p][q]) begin
            prod_q[p][q] <= win_q[p][q] * coef_sel[p][q];
          end else begin
            prod_q[p][q] <= '0;
          end
        end
      end
      meta3_q <= meta2_q;
    end
  end

  // stage 4: row sums
  logic signed [cvs_pkg::RSUM_W-1:0] rsum_q [K];
  logic                              v4_q;
  cvs_pkg::cvs_meta_t                meta4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < K; p++) begin
        rsum_q[p] <= cvs_pkg::RSUM_W'(prod_q[p][0]) +
                     cvs_pkg::RSUM_W'(prod_q[p][1]) +
                     cvs_pkg::RSUM_W'(prod_q[p][2]);
      end
      meta4_q <= meta3_q;
    end
  end

  // output register
  logic signed [cvs_pkg::SUM_W-1:0] sum_q;
  cvs_pkg::cvs_meta_t               meta_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= cvs_pkg::SUM_W'(rsum_q[0]) + cvs_pkg::SUM_W'(rsum_q[1]) +
               cvs_pkg::SUM_W'(rsum_q[2]);
      meta_out_q <= meta4_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.sum        = sum_q;
  assign res_o.out_row    = meta_out_q.out_row;
  assign res_o.out_col    = meta_out_q.out_col;
  assign res_o.frame_last = meta_out_q.frame_last;

  // a held result stops the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !pix_i.ready)
    else $error("input taken while a result is held");

  // the bypass is only set for a column repeated by back-to-back pixels
  a_fwd_same_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (v1_q && $past(v1_q) && (addr1_q == $past(addr1_q))))
    else $error("line store bypass without a matching write");

  // row counter wraps before its all-ones code
  a_row_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != '1)
    else $error("row counter out of range");

  // window stage valid only behind a pixel or while held by a stall
  a_window_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q || !adv))
    else $error("window stage valid without a pixel");

endmodule
